FILE: design/bia_pkg.sv
`default_nettype none

package bia_pkg;

  localparam int ID_W = 16;
  localparam logic [ID_W-1:0] BASE_RESET = 16'd300;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_INIT    = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  typedef struct packed {
    logic       accept;
    logic       addr_clr;
    logic       clear_step;
    logic       scan_step;
    logic       alloc_wr;
    logic       rel_rd;
    logic       rel_wr;
    logic       pend_ld;
    logic       pend_grant;
    logic [1:0] pend_status;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic clear_last;
    logic hit;
    logic exhausted;
  } stat_t;

endpackage

`default_nettype wire

FILE: design/bia_if.sv
`default_nettype none

interface bia_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] id_value;

  modport source (output valid, output mode, output id_value, input ready);
  modport sink (input valid, input mode, input id_value, output ready);
endinterface

interface bia_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] granted_id;

  modport source (output valid, output status, output granted_id, input ready);
  modport sink (input valid, input status, input granted_id, output ready);
endinterface

`default_nettype wire

FILE: design/bia_ram.sv
`default_nettype none

module bia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/bia_dp.sv
`default_nettype none

module bia_dp import bia_pkg::*; #(
  parameter int ID_COUNT = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [ID_W-1:0] cfg_wdata,
  input  wire logic [ID_W-1:0] in_id,
  input  wire cmd_t            cmd,
  output stat_t                st,
  output logic [1:0]           out_status,
  output logic [ID_W-1:0]      out_id
);

  localparam int WORD_W = (ID_COUNT < 64) ? ID_COUNT : 64;
  localparam int DEPTH  = ID_COUNT / WORD_W;
  localparam int WB     = $clog2(WORD_W);
  localparam int IDX_W  = $clog2(ID_COUNT);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIM_W  = ID_W + 1;
  localparam int TW     = WORD_W + 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [ID_W-1:0]   base_id;
  logic [IDX_W-1:0]  off;
  logic [ADDR_W-1:0] scan_addr;
  logic [ADDR_W-1:0] chk_addr;
  logic              chk_vld;
  logic [1:0]        pend_status;
  logic [ID_W-1:0]   pend_id;

  logic [LIM_W-1:0]  room;
  logic [LIM_W-1:0]  limit;
  logic [IDX_W-1:0]  lim_m1;
  logic [ADDR_W-1:0] last_word;
  logic [WB-1:0]     last_bit;
  logic [LIM_W-1:0]  id_diff;
  logic [ADDR_W-1:0] off_word;
  logic [WB-1:0]     off_bit;
  logic [TW-1:0]     thermo;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] free;
  logic [WB-1:0]     pos;
  logic [IDX_W-1:0]  idx;
  logic [ID_W-1:0]   grant;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // usable range, clipped so identifiers never wrap
  always_comb begin
    room      = (LIM_W'(1) << ID_W) - LIM_W'(base_id);
    limit     = (LIM_W'(ID_COUNT) < room) ? LIM_W'(ID_COUNT) : room;
    lim_m1    = IDX_W'(limit - LIM_W'(1));
    last_word = ADDR_W'(lim_m1 >> WB);
    last_bit  = WB'(lim_m1);
    id_diff   = LIM_W'(in_id) - LIM_W'(base_id);
    off_word  = ADDR_W'(off >> WB);
    off_bit   = WB'(off);
  end

  // first free bit of the checked word
  always_comb begin
    thermo = (TW'(2) << last_bit) - TW'(1);
    mask   = (chk_addr == last_word) ? thermo[WORD_W-1:0] : '1;
    free   = ~ram_rdata & mask;
    pos    = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free[i]) begin
        pos = WB'(i);
      end
    end
    idx   = IDX_W'({chk_addr, pos});
    grant = base_id + ID_W'(idx);
  end

  always_comb begin
    st.in_range   = (in_id >= base_id) && (id_diff < limit);
    st.clear_last = (scan_addr == LAST_ADDR);
    st.hit        = chk_vld && (|free);
    st.exhausted  = chk_vld && !(|free) && (chk_addr == last_word);
  end

  always_comb begin
    ram_we    = cmd.clear_step | cmd.alloc_wr | cmd.rel_wr;
    ram_waddr = scan_addr;
    ram_wdata = '0;
    if (cmd.alloc_wr) begin
      ram_waddr = chk_addr;
      ram_wdata = ram_rdata | (WORD_W'(1) << pos);
    end else if (cmd.rel_wr) begin
      ram_waddr = off_word;
      ram_wdata = ram_rdata & ~(WORD_W'(1) << off_bit);
    end
    ram_raddr = cmd.rel_rd ? off_word : scan_addr;
  end

  bia_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_id   <= BASE_RESET;
      scan_addr <= '0;
      chk_vld   <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_id <= cfg_wdata;
      end
      if (cmd.addr_clr) begin
        scan_addr <= '0;
      end else if (cmd.clear_step || cmd.scan_step) begin
        scan_addr <= scan_addr + ADDR_W'(1);
      end
      chk_vld <= cmd.scan_step && !cmd.addr_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      chk_addr <= scan_addr;
    end
    if (cmd.accept) begin
      off <= IDX_W'(id_diff);
    end
    if (cmd.pend_ld) begin
      pend_status <= cmd.pend_status;
      pend_id     <= cmd.pend_grant ? grant : '0;
    end
    if (cmd.out_ld) begin
      out_status <= pend_status;
      out_id     <= pend_id;
    end
  end

endmodule

`default_nettype wire

FILE: design/bia_ctrl.sv
`default_nettype none

module bia_ctrl import bia_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_mode,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire stat_t      st,
  output cmd_t            cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_REL_RD = 3'd3;
  localparam logic [2:0] S_REL_WR = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       map_ready;
  logic       map_ready_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    map_ready_next = map_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept   = 1'b1;
          cmd.addr_clr = 1'b1;
          case (in_mode)
            MODE_INIT: begin
              state_next = S_CLEAR;
            end
            MODE_ALLOC: begin
              if (!map_ready) begin
                cmd.pend_ld     = 1'b1;
                cmd.pend_status = ST_NOT_READY;
                state_next      = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            MODE_RELEASE: begin
              if (!map_ready) begin
                cmd.pend_ld     = 1'b1;
                cmd.pend_status = ST_NOT_READY;
                state_next      = S_DONE;
              end else if (!st.in_range) begin
                cmd.pend_ld     = 1'b1;
                cmd.pend_status = ST_INVALID;
                state_next      = S_DONE;
              end else begin
                state_next = S_REL_RD;
              end
            end
            default: begin
              cmd.pend_ld     = 1'b1;
              cmd.pend_status = ST_OK;
              state_next      = S_DONE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) begin
          map_ready_next  = 1'b1;
          cmd.pend_ld     = 1'b1;
          cmd.pend_status = ST_OK;
          state_next      = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.hit) begin
          cmd.alloc_wr    = 1'b1;
          cmd.pend_ld     = 1'b1;
          cmd.pend_grant  = 1'b1;
          cmd.pend_status = ST_OK;
          state_next      = S_DONE;
        end else if (st.exhausted) begin
          cmd.pend_ld     = 1'b1;
          cmd.pend_status = ST_FULL;
          state_next      = S_DONE;
        end
      end
      S_REL_RD: begin
        cmd.rel_rd = 1'b1;
        state_next = S_REL_WR;
      end
      S_REL_WR: begin
        cmd.rel_wr      = 1'b1;
        cmd.pend_ld     = 1'b1;
        cmd.pend_status = ST_OK;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      map_ready <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      map_ready <= map_ready_next;
      if (cmd.out_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_step, cmd.alloc_wr, cmd.rel_wr}))
    else $error("more than one map write in a cycle");

  a_ready_from_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(map_ready) |-> $past(state) == S_CLEAR)
    else $error("map marked ready outside the clear sweep");

  a_hit_ends_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && st.hit |=> state == S_DONE)
    else $error("scan did not stop at a free bit");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_valid && !out_ready |=> state == S_DONE)
    else $error("result slot overwritten while occupied");

endmodule

`default_nettype wire

FILE: design/bitmap_id_allocator.sv
`default_nettype none

// First-fit identifier allocator over a bitmap of ID_COUNT in-use flags kept
// in a RAM of 64-bit words (narrower when ID_COUNT is below 64). One item is
// handled at a time. Allocate scans words from index zero, one RAM read a
// cycle, up to the first free bit, reading at most ID_COUNT/64 words (64 at
// the default size). Release is a read-modify-write of one word, initialise
// clears one word a cycle, and an item with no work answers ok without
// touching the map. After reset the map reads as not ready and every
// allocate or release answers not-ready until an initialise, so no clearing
// pass runs after reset. base_id is written through cfg_we/cfg_wdata; the
// user must write it only while the block is idle, which the block itself
// does not enforce. The flags stay bound to their indices when it changes.

module bitmap_id_allocator import bia_pkg::*; #(
  parameter int ID_COUNT = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst,
  bia_req_if.sink              req,
  bia_rsp_if.source            rsp,
  input  wire logic            cfg_we,
  input  wire logic [ID_W-1:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t st;
  logic  in_ready;
  logic  out_valid;

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

  bia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_mode   (req.mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  bia_dp #(
    .ID_COUNT (ID_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_id      (req.id_value),
    .cmd        (cmd),
    .st         (st),
    .out_status (rsp.status),
    .out_id     (rsp.granted_id)
  );

endmodule

`default_nettype wire
